### hw/rtl/itt_pkg.sv
// shared types and constants of the interval task timer table
package itt_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int ID_W      = 31;
	localparam int TIME_W    = 32;

	localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
	localparam logic [ID_W-1:0] ID_LAST  = {ID_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_REMOVED  = 3'd2,
		KIND_NOTFOUND = 3'd3,
		KIND_FIRED    = 3'd4,
		KIND_DONE     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [ID_W-1:0] interval;
		logic            repeat_req;
		logic [ID_W-1:0] target_id;
	} cmd_t;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] result_id;
		logic            last;
	} res_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   interval;
		logic [TIME_W-1:0] last_run;
		logic              periodic;
	} entry_t;

	typedef struct packed {
		logic   fire;
		logic   keep;
		logic   match;
		entry_t entry;
	} eval_t;

endpackage

### hw/rtl/itt_entry_eval.sv
// per-entry decision for the table scan: match on remove, fire and keep on tick
module itt_entry_eval (
	input  logic                      is_tick,
	input  logic [itt_pkg::TIME_W-1:0] now,
	input  logic [itt_pkg::ID_W-1:0]   target_id,
	input  itt_pkg::entry_t           ent,
	output itt_pkg::eval_t            ev
);
	import itt_pkg::*;

	logic [TIME_W-1:0] elapsed;
	logic              due;

	// unsigned distance, wraps with the time counter
	assign elapsed = now - ent.last_run;
	assign due     = elapsed >= {1'b0, ent.interval};

	always_comb begin
		ev.entry = ent;
		ev.match = 1'b0;
		ev.fire  = 1'b0;
		ev.keep  = 1'b1;
		if (is_tick) begin
			ev.fire = due;
			ev.keep = !due || ent.periodic;
			if (due) begin
				ev.entry.last_run = now;
			end
		end else begin
			ev.match = ent.id == target_id;
			ev.keep  = !ev.match;
		end
	end

endmodule

### hw/rtl/interval_task_timer_table_unit.sv
// Interval task timer table: entries live in one single-port-write, one-read synchronous
// memory in insertion order. An add writes its entry when taken, if there is room, and gives
// its result from the FIN state. A remove or a tick walks the stored entries one per cycle
// through the memory read port, held while a fired result waits on res_stall, writing kept
// entries back compacted toward the front, then gives its final result from FIN, which can
// also wait on res_stall. Commands are taken one at a time; cmd_stall is low only between
// commands. The memory needs no clearing pass after reset since only the first entry-count
// entries are ever read.
module interval_task_timer_table_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  itt_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output itt_pkg::res_t  res
);
	import itt_pkg::*;

	entry_t mem [MAX_TASKS];
	entry_t rdata_s1;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [TIME_W-1:0]  time_q;
	logic [ID_W-1:0]    next_id_q;
	logic               tick_q;
	logic [ID_W-1:0]    target_q;
	logic               found_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic [CNT_W-1:0]   wr_idx_q;
	logic               rd_pend_s1;
	kind_t              fin_kind_q;
	logic [ID_W-1:0]    fin_id_q;
	logic               res_valid_q;
	res_t               res_q;

	eval_t              ev;
	logic               can_push;
	logic               advance;
	logic               accept;
	logic               mem_we;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	logic               push;
	res_t               push_res;

	itt_entry_eval u_eval (
		.is_tick   (tick_q),
		.now       (time_q),
		.target_id (target_q),
		.ent       (rdata_s1),
		.ev        (ev)
	);

	assign cmd_stall = state_q != ST_IDLE;
	assign accept    = cmd_valid && !cmd_stall;
	assign can_push  = !res_valid_q || !res_stall;
	// hold the scan while a fired result cannot leave
	assign advance   = !rd_pend_s1 || !ev.fire || can_push;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = wr_idx_q[IDX_W-1:0];
		mem_wdata = ev.entry;
		push      = 1'b0;
		push_res  = '{kind: KIND_FIRED, result_id: rdata_s1.id, last: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.opcode)
						OP_ADD: begin
							state_d = ST_FIN;
							if (count_q < CNT_W'(MAX_TASKS)) begin
								mem_we    = 1'b1;
								mem_waddr = count_q[IDX_W-1:0];
								mem_wdata = '{id: next_id_q, interval: cmd.interval,
									last_run: time_q, periodic: cmd.repeat_req};
							end
						end
						OP_REMOVE, OP_TICK: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (advance) begin
					if (rd_pend_s1) begin
						mem_we = ev.keep;
						push   = ev.fire;
					end
					if (scan_idx_q < count_q) begin
						mem_re = 1'b1;
					end else if (!rd_pend_s1) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (can_push) begin
					push     = 1'b1;
					push_res = '{kind: fin_kind_q, result_id: fin_id_q, last: 1'b1};
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[scan_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			time_q      <= '0;
			next_id_q   <= ID_FIRST;
			tick_q      <= 1'b0;
			found_q     <= 1'b0;
			scan_idx_q  <= '0;
			wr_idx_q    <= '0;
			rd_pend_s1  <= 1'b0;
			fin_kind_q  <= KIND_DONE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tick_q     <= cmd.opcode == OP_TICK;
						found_q    <= 1'b0;
						scan_idx_q <= '0;
						wr_idx_q   <= '0;
						rd_pend_s1 <= 1'b0;
						case (cmd.opcode)
							OP_ADD: begin
								if (count_q < CNT_W'(MAX_TASKS)) begin
									count_q    <= count_q + CNT_W'(1);
									fin_kind_q <= KIND_ADDED;
									next_id_q  <= (next_id_q == ID_LAST) ? ID_FIRST
										: next_id_q + ID_W'(1);
								end else begin
									fin_kind_q <= KIND_FULL;
								end
							end
							OP_TICK: time_q <= time_q + TIME_W'(1);
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (rd_pend_s1) begin
							if (ev.keep) begin
								wr_idx_q <= wr_idx_q + CNT_W'(1);
							end
							if (ev.match) begin
								found_q <= 1'b1;
							end
						end
						if (mem_re) begin
							scan_idx_q <= scan_idx_q + CNT_W'(1);
						end
						rd_pend_s1 <= mem_re;
						if (state_d == ST_FIN) begin
							count_q <= wr_idx_q;
							if (tick_q) begin
								fin_kind_q <= KIND_DONE;
							end else begin
								fin_kind_q <= found_q ? KIND_REMOVED : KIND_NOTFOUND;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= cmd.target_id;
			if (cmd.opcode == OP_ADD && count_q < CNT_W'(MAX_TASKS)) begin
				fin_id_q <= next_id_q;
			end else begin
				fin_id_q <= '0;
			end
		end else if (state_q == ST_SCAN && state_d == ST_FIN) begin
			fin_id_q <= (!tick_q && found_q) ? target_q : '0;
		end
		if (push) begin
			res_q <= push_res;
		end
	end

endmodule

### hw/rtl/itt_checker.sv
// port-level checks for the interval task timer table, bound to the top level
module itt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input itt_pkg::cmd_t cmd,
	input logic          res_valid,
	input logic          res_stall,
	input itt_pkg::res_t res
);
	import itt_pkg::*;

	// a waiting result holds until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// any real command keeps the block busy in the next cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall &&
		(cmd.opcode == OP_ADD || cmd.opcode == OP_REMOVE || cmd.opcode == OP_TICK)
		|=> cmd_stall)
		else $error("command transfer did not start work");

	// only fired results are not the final one of a command
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last == (res.kind != KIND_FIRED)))
		else $error("last flag does not match result kind");

	// an id handed out is never zero
	a_added_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_ADDED || res.kind == KIND_FIRED ||
		res.kind == KIND_REMOVED) |-> res.result_id != '0)
		else $error("zero id reported");

endmodule

bind interval_task_timer_table_unit itt_checker u_itt_checker (.*);
